>>> design/byte_stream_tokenizer_macros.svh
// assertion macros shared by the tokenizer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef BYTE_STREAM_TOKENIZER_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define BST_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bst_pkg.sv
// shared types, constants and decode functions of the byte stream tokenizer
// no dependencies; used by every design module
package bst_pkg;

	localparam int WORD_LIMIT = 63;
	localparam int WL_W       = $clog2(WORD_LIMIT + 1);
	localparam int BYTE_W     = 8;
	localparam int ID_W       = 14;
	localparam int CNT_W      = 16;
	localparam int CP_W       = 21;

	// token ids
	localparam logic [ID_W-1:0] TOK_BOS        = 14'd0;
	localparam logic [ID_W-1:0] TOK_EOS        = 14'd1;
	localparam logic [ID_W-1:0] TOK_UNK        = 14'd3;
	localparam logic [ID_W-1:0] TOK_DIGIT_BASE = 14'd4;
	localparam logic [ID_W-1:0] TOK_PUNCT_BASE = 14'd14;
	localparam logic [ID_W-1:0] ARABIC_BASE    = 14'd1000;
	localparam logic [ID_W-1:0] OTHER_BASE     = 14'd6000;
	localparam logic [ID_W-1:0] MAX_ID         = 14'd15999;

	// remainder moduli
	localparam logic [ID_W-1:0] MOD_LO = 14'd5000;
	localparam logic [ID_W-1:0] MOD_HI = 14'd10000;

	// divide by 10000 as (cp >> 4) / 625 through a reciprocal, exact for 17 bits
	localparam int DIV_SHIFT   = 4;
	localparam int DIV_X_W     = CP_W - DIV_SHIFT;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 27;
	localparam int PROD_W      = DIV_X_W + RECIP_W;
	localparam int Q_W         = 8;
	localparam logic [RECIP_W-1:0] RECIP = 18'd214749;

	// utf-8 lead bytes
	localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
	localparam logic [BYTE_W-1:0] TEXT_END  = 8'h00;

	// queue depths
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_AW      = $clog2(OUT_DEPTH);

	localparam int NUM_PUNCT = 12;
	localparam logic [BYTE_W-1:0] PUNCT_CHARS [NUM_PUNCT] = '{
		8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B, 8'h3D,
		8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h23, 8'h2E
	};

	// work handed from the front to the back, one per byte that gives results
	typedef struct packed {
		logic             two;
		logic [ID_W-1:0]  id0;
		logic             present0;
		logic             cp0;
		logic [ID_W-1:0]  id1;
		logic [CP_W-1:0]  cp;
		logic             done;
		logic [CNT_W-1:0] total;
	} entry_t;

	typedef struct packed {
		logic [ID_W-1:0]  token_id;
		logic             token_present;
		logic             text_done;
		logic [CNT_W-1:0] total_tokens;
		logic             last_of_run;
	} result_t;

	function automatic logic is_space(input logic [BYTE_W-1:0] b);
		return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_punct(input logic [BYTE_W-1:0] b);
		return b inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
	endfunction

	function automatic logic [ID_W-1:0] punct_id(input logic [BYTE_W-1:0] b);
		logic [ID_W-1:0] id;
		id = TOK_UNK;
		for (int i = NUM_PUNCT - 1; i >= 0; i--) begin
			if (PUNCT_CHARS[i] == b) begin
				id = TOK_PUNCT_BASE + ID_W'(i);
			end
		end
		return id;
	endfunction

	function automatic logic [ID_W-1:0] word_id(input logic [WL_W-1:0] len,
			input logic [BYTE_W-1:0] first);
		logic [BYTE_W-1:0] d;
		d = first - 8'h30;
		if (len == WL_W'(1) && first inside {[8'h30:8'h39]}) begin
			return TOK_DIGIT_BASE + ID_W'(d);
		end
		return TOK_UNK;
	endfunction

	function automatic logic in_arabic(input logic [CP_W-1:0] c);
		return c inside {[21'h000600:21'h0006FF], [21'h000750:21'h00077F],
			[21'h0008A0:21'h0008FF], [21'h00FB50:21'h00FDFF], [21'h00FE70:21'h00FEFF]};
	endfunction

endpackage

>>> design/bst_queue.sv
// short queue of work entries between the tokenizer front and back
// depends on bst_pkg
module bst_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bst_pkg::entry_t wdata,
	output logic           full,
	input  logic           pop,
	output bst_pkg::entry_t rdata,
	output logic           empty
);

	bst_pkg::entry_t mem_q [bst_pkg::QUEUE_DEPTH];
	logic [bst_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [bst_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [bst_pkg::QUEUE_AW:0]   count_q;
	logic do_push;
	logic do_pop;

	assign full    = count_q == (bst_pkg::QUEUE_AW + 1)'(bst_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (bst_pkg::QUEUE_AW + 1)'(do_push)
				- (bst_pkg::QUEUE_AW + 1)'(do_pop);
		end
	end

endmodule

>>> design/bst_front.sv
// tokenizer front: classifies each byte, keeps word, utf-8 and count state
// depends on bst_pkg; writes one entry per byte that gives results
module bst_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [bst_pkg::BYTE_W-1:0]  text_byte,
	input  logic                        cfg_wr_en,
	input  logic [bst_pkg::CNT_W-1:0]   cfg_wr_data,
	output logic                        entry_valid,
	output bst_pkg::entry_t             entry
);

	localparam int CW = bst_pkg::CNT_W;

	logic [CW-1:0]               max_tokens_q;
	logic                        begun_q;
	logic                        limit_q;
	logic [bst_pkg::WL_W-1:0]    word_len_q;
	logic [bst_pkg::BYTE_W-1:0]  first_q;
	logic [1:0]                  utf_left_q;
	logic [bst_pkg::CP_W-1:0]    cp_q;
	logic [CW-1:0]               count_q;

	logic                        limit_n;
	logic [bst_pkg::WL_W-1:0]    word_len_n;
	logic [bst_pkg::BYTE_W-1:0]  first_n;
	logic [1:0]                  utf_left_n;
	logic [bst_pkg::CP_W-1:0]    cp_n;
	logic [CW-1:0]               count_n;

	logic                        is_end;
	logic                        bos;
	logic                        wb;
	logic                        hc;
	logic                        c_cp;
	logic                        start;
	logic [bst_pkg::ID_W-1:0]    id_b;
	logic [bst_pkg::ID_W-1:0]    id_c;
	logic [bst_pkg::CP_W-1:0]    cp_shift;
	logic [bst_pkg::WL_W-1:0]    word_inc;
	logic [CW-1:0]               lim;
	logic [CW-1:0]               tc0;
	logic [CW-1:0]               tc_mid;
	logic [CW-1:0]               tc_fin;
	logic [1:0]                  n_res;

	assign is_end   = text_byte == bst_pkg::TEXT_END;
	assign bos      = !begun_q;
	assign lim      = (max_tokens_q == '0) ? CW'(1) : max_tokens_q;
	assign tc0      = count_q + CW'(bos);
	assign cp_shift = {cp_q[bst_pkg::CP_W-7:0], text_byte[5:0]};
	assign word_inc = word_len_q + 1'b1;

	always_comb begin
		limit_n    = limit_q;
		word_len_n = word_len_q;
		first_n    = first_q;
		utf_left_n = utf_left_q;
		cp_n       = cp_q;
		wb         = 1'b0;
		hc         = 1'b0;
		c_cp       = 1'b0;
		start      = 1'b0;
		id_b       = bst_pkg::word_id(word_len_q, first_q);
		id_c       = bst_pkg::TOK_EOS;
		tc_mid     = tc0;
		if (is_end) begin
			// flush a pending word, then the end token if it fits
			wb     = word_len_q != '0;
			tc_mid = tc0 + CW'(wb);
			hc     = tc_mid < lim;
		end else if (limit_q) begin
			// drop bytes until the text ends
		end else if (utf_left_q != 2'd0) begin
			cp_n       = cp_shift;
			utf_left_n = utf_left_q - 2'd1;
			if (utf_left_q == 2'd1) begin
				hc   = 1'b1;
				c_cp = 1'b1;
				cp_n = '0;
			end
		end else begin
			if (word_len_q != '0) begin
				if (bst_pkg::is_space(text_byte)) begin
					wb         = 1'b1;
					word_len_n = '0;
					first_n    = '0;
				end else if (bst_pkg::is_punct(text_byte)) begin
					wb         = 1'b1;
					word_len_n = '0;
					first_n    = '0;
					start      = 1'b1;
				end else if (word_inc >= bst_pkg::WL_W'(bst_pkg::WORD_LIMIT)) begin
					// split a long word
					wb         = 1'b1;
					id_b       = bst_pkg::word_id(word_inc, first_q);
					word_len_n = '0;
					first_n    = '0;
				end else begin
					word_len_n = word_inc;
				end
			end else begin
				start = !bst_pkg::is_space(text_byte);
			end
			tc_mid = tc0 + CW'(wb);
			if (start) begin
				if (({1'b0, tc_mid} + (CW + 1)'(1)) >= {1'b0, lim}) begin
					limit_n = 1'b1;
				end else if (text_byte >= bst_pkg::LEAD2_MIN) begin
					if (text_byte < bst_pkg::LEAD3_MIN) begin
						utf_left_n = 2'd1;
						cp_n       = bst_pkg::CP_W'(text_byte & 8'h1F);
					end else if (text_byte < bst_pkg::LEAD4_MIN) begin
						utf_left_n = 2'd2;
						cp_n       = bst_pkg::CP_W'(text_byte & 8'h0F);
					end else begin
						utf_left_n = 2'd3;
						cp_n       = bst_pkg::CP_W'(text_byte & 8'h07);
					end
				end else if (bst_pkg::is_punct(text_byte)) begin
					hc   = 1'b1;
					id_c = bst_pkg::punct_id(text_byte);
				end else if (bst_pkg::WORD_LIMIT <= 1) begin
					hc   = 1'b1;
					id_c = bst_pkg::word_id(bst_pkg::WL_W'(1), text_byte);
				end else begin
					word_len_n = bst_pkg::WL_W'(1);
					first_n    = text_byte;
				end
			end
		end
		tc_fin  = tc_mid + CW'(hc);
		count_n = tc_fin;
	end

	assign n_res = 2'(bos) + 2'(wb) + 2'(hc);

	always_comb begin
		entry.two      = n_res == 2'd2;
		entry.present0 = n_res != 2'd0;
		entry.cp0      = !bos && !wb && hc && c_cp;
		entry.id1      = id_c;
		entry.cp       = cp_shift;
		entry.done     = is_end;
		entry.total    = is_end ? tc_fin : '0;
		if (bos) begin
			entry.id0 = bst_pkg::TOK_BOS;
		end else if (wb) begin
			entry.id0 = id_b;
		end else if (hc) begin
			entry.id0 = id_c;
		end else begin
			entry.id0 = bst_pkg::TOK_BOS;
		end
	end

	assign entry_valid = accept && (n_res != 2'd0 || is_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= '1;
			begun_q      <= 1'b0;
			limit_q      <= 1'b0;
			word_len_q   <= '0;
			first_q      <= '0;
			utf_left_q   <= '0;
			cp_q         <= '0;
			count_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_tokens_q <= cfg_wr_data;
			end
			if (accept) begin
				if (is_end) begin
					begun_q    <= 1'b0;
					limit_q    <= 1'b0;
					word_len_q <= '0;
					first_q    <= '0;
					utf_left_q <= '0;
					cp_q       <= '0;
					count_q    <= '0;
				end else begin
					begun_q    <= 1'b1;
					limit_q    <= limit_n;
					word_len_q <= word_len_n;
					first_q    <= first_n;
					utf_left_q <= utf_left_n;
					cp_q       <= cp_n;
					count_q    <= count_n;
				end
			end
		end
	end

endmodule

>>> design/bst_back.sv
// tokenizer back: code point to id in two stages, results into an output queue
// depends on bst_pkg; reads entries from bst_queue
module bst_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  bst_pkg::entry_t q_head,
	output logic            q_pop,
	input  logic            res_pop,
	output logic            res_empty,
	output bst_pkg::result_t res_head
);

	localparam int IW = bst_pkg::ID_W;
	localparam int PW = bst_pkg::PROD_W;

	logic                     vld_s1;
	bst_pkg::entry_t          ent_s1;
	logic [bst_pkg::Q_W-1:0]  quo_s1;
	logic                     arab_s1;

	logic                     vld_s2;
	bst_pkg::entry_t          ent_s2;
	logic [IW-1:0]            rem_s2;
	logic                     arab_s2;
	logic                     idx_q;

	bst_pkg::result_t         out_mem_q [bst_pkg::OUT_DEPTH];
	logic [bst_pkg::OUT_AW-1:0] out_wr_q;
	logic [bst_pkg::OUT_AW-1:0] out_rd_q;
	logic [bst_pkg::OUT_AW:0]   out_cnt_q;

	logic [PW-1:0]            prod;
	logic [bst_pkg::CP_W-1:0] diff;
	logic [IW-1:0]            rem5;
	logic [IW-1:0]            cp_id;
	logic                     out_full;
	logic                     emit;
	logic                     last_now;
	logic                     s2_free;
	logic                     mv12;
	logic                     do_pop;
	bst_pkg::result_t         res;

	// quotient by 10000, exact over the 21-bit code point range
	assign prod = PW'(q_head.cp[bst_pkg::CP_W-1:bst_pkg::DIV_SHIFT]) * PW'(bst_pkg::RECIP);
	assign diff = ent_s1.cp - bst_pkg::CP_W'(quo_s1) * bst_pkg::CP_W'(bst_pkg::MOD_HI);

	assign rem5  = (rem_s2 >= bst_pkg::MOD_LO) ? rem_s2 - bst_pkg::MOD_LO : rem_s2;
	assign cp_id = arab_s2 ? bst_pkg::ARABIC_BASE + rem5 : bst_pkg::OTHER_BASE + rem_s2;

	assign out_full = out_cnt_q == (bst_pkg::OUT_AW + 1)'(bst_pkg::OUT_DEPTH);
	assign emit     = vld_s2 && !out_full;
	assign last_now = !ent_s2.two || idx_q;
	assign s2_free  = !vld_s2 || (emit && last_now);
	assign mv12     = vld_s1 && s2_free;
	assign q_pop    = !q_empty && (!vld_s1 || mv12);
	assign do_pop   = res_pop && !res_empty;

	always_comb begin
		if (!idx_q) begin
			res.token_id      = ent_s2.cp0 ? cp_id : ent_s2.id0;
			res.token_present = ent_s2.present0;
		end else begin
			res.token_id      = ent_s2.id1;
			res.token_present = 1'b1;
		end
		res.last_of_run  = last_now;
		res.text_done    = last_now && ent_s2.done;
		res.total_tokens = last_now ? ent_s2.total : '0;
	end

	assign res_empty = out_cnt_q == '0;
	assign res_head  = out_mem_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_s1  <= q_head;
			quo_s1  <= prod[bst_pkg::RECIP_SHIFT+bst_pkg::Q_W-1:bst_pkg::RECIP_SHIFT];
			arab_s1 <= bst_pkg::in_arabic(q_head.cp);
		end
		if (mv12) begin
			ent_s2  <= ent_s1;
			rem_s2  <= diff[IW-1:0];
			arab_s2 <= arab_s1;
		end
		if (emit) begin
			out_mem_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			idx_q     <= 1'b0;
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (q_pop) begin
				vld_s1 <= 1'b1;
			end else if (mv12) begin
				vld_s1 <= 1'b0;
			end
			if (mv12) begin
				vld_s2 <= 1'b1;
			end else if (s2_free) begin
				vld_s2 <= 1'b0;
			end
			if (emit) begin
				idx_q    <= !last_now;
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (do_pop) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			out_cnt_q <= out_cnt_q + (bst_pkg::OUT_AW + 1)'(emit)
				- (bst_pkg::OUT_AW + 1)'(do_pop);
		end
	end

endmodule

>>> design/byte_stream_tokenizer.sv
// byte stream tokenizer top level: front, work queue and back
// depends on bst_pkg, bst_front, bst_queue and bst_back
//
// usage
//   input side is a queue: drive text_byte with push; the item is taken at a
//   clock edge where push is high and full is low. byte 0 ends a text.
//   result side is a queue: while empty is low the oldest result sits on
//   token_id, token_present, text_done, total_tokens and last_of_run; it is
//   taken at an edge where pop is high.
//   max_tokens is written through cfg_wr_en / cfg_wr_data between texts.
// timing
//   one byte per cycle is taken as long as results drain; a byte that gives
//   two results (start token plus another, word plus punctuation, word plus
//   end token) sends them out one after the other on the result side.
//   the first result of a byte reaches the ports through the front into the
//   4-entry work queue, the reciprocal multiply stage and the remainder stage
//   into the 4-entry result queue.
// stall
//   if pop stays low the result queue fills, the back stops, the work queue
//   fills and full rises; no item is lost or repeated.
// reset
//   arst_n clears all text state and both queues; max_tokens returns to 65535.
//   no clearing pass, items are taken from the first cycle after reset.
module byte_stream_tokenizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [bst_pkg::BYTE_W-1:0]  text_byte,
	input  logic                        cfg_wr_en,
	input  logic [bst_pkg::CNT_W-1:0]   cfg_wr_data,
	output logic                        empty,
	input  logic                        pop,
	output logic [bst_pkg::ID_W-1:0]    token_id,
	output logic                        token_present,
	output logic                        text_done,
	output logic [bst_pkg::CNT_W-1:0]   total_tokens,
	output logic                        last_of_run
);

	logic             accept;
	logic             entry_valid;
	bst_pkg::entry_t  entry;
	logic             q_pop;
	logic             q_empty;
	bst_pkg::entry_t  q_head;
	bst_pkg::result_t res_head;

	// a byte is taken whenever the work queue has room
	assign accept = push && !full;

	// classify bytes and track word / utf-8 / token count state
	bst_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.entry_valid (entry_valid),
		.entry       (entry)
	);

	// decouples the front from stalls on the result side
	bst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (entry_valid),
		.wdata  (entry),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_head),
		.empty  (q_empty)
	);

	// code point ids and splitting of two-result items
	bst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_pop   (pop),
		.res_empty (empty),
		.res_head  (res_head)
	);

	assign token_id      = res_head.token_id;
	assign token_present = res_head.token_present;
	assign text_done     = res_head.text_done;
	assign total_tokens  = res_head.total_tokens;
	assign last_of_run   = res_head.last_of_run;

endmodule

>>> design/bst_checker.sv
// port-level checks of the byte stream tokenizer, bound to the top level
// depends on bst_pkg and byte_stream_tokenizer_macros.svh
`include "byte_stream_tokenizer_macros.svh"

module bst_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [bst_pkg::ID_W-1:0]    token_id,
	input logic                        token_present,
	input logic                        text_done,
	input logic [bst_pkg::CNT_W-1:0]   total_tokens,
	input logic                        last_of_run
);

	// a result without a token is only the bare end report
	`BST_ASSERT_IMPL(a_bare_end, !empty && !token_present, text_done && last_of_run, "bare result not an end report")
	// the end of a text closes the run of its byte
	`BST_ASSERT_IMPL(a_done_last, !empty && text_done, last_of_run, "text_done without last_of_run")
	// the total is reported only with the end of a text
	`BST_ASSERT_IMPL(a_total_zero, !empty && !text_done, total_tokens == '0, "total outside text end")
	// ids stay inside the vocabulary
	`BST_ASSERT_IMPL(a_id_range, !empty, token_id <= bst_pkg::MAX_ID, "token id out of range")
	// a waiting result holds until taken
	`BST_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(token_id), "waiting result changed")

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.token_id      (token_id),
	.token_present (token_present),
	.text_done     (text_done),
	.total_tokens  (total_tokens),
	.last_of_run   (last_of_run)
);

>>> dv/tb_byte_stream_tokenizer.sv
// testbench for the byte stream tokenizer: queue-fed byte sender, stalling receiver, token checker
// depends on bst_pkg and byte_stream_tokenizer from the design folder
module tb_byte_stream_tokenizer;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 9;
	// results trail their byte through the work queue and both back stages; wait well beyond that when idle
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int MAX_PER_BYTE  = 2;
	localparam int MAX_PRINTED   = 40;
	localparam int ARABIC_MOD    = 5000;
	localparam int OTHER_MOD     = 10000;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// punctuation with its own token, in vocabulary order: ( ) { } ; = + - * / # .
	localparam logic [7:0] VOCAB_PUNCT [12] = '{
		8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B, 8'h3D,
		8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h23, 8'h2E
	};

	typedef enum logic [1:0] {CMD_BYTE, CMD_CFG, CMD_DRAIN, CMD_HOLD} cmd_kind_t;

	typedef struct {
		cmd_kind_t   kind;
		logic [15:0] value;
	} cmd_t;

	typedef struct packed {
		logic [bst_pkg::ID_W-1:0]  id;
		logic                      present;
		logic                      done;
		logic [bst_pkg::CNT_W-1:0] total;
		logic                      last;
	} token_result_t;

	// dut ports, all inputs known from time zero
	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        push        = 1'b0;
	logic [bst_pkg::BYTE_W-1:0]  text_byte   = '0;
	logic                        cfg_wr_en   = 1'b0;
	logic [bst_pkg::CNT_W-1:0]   cfg_wr_data = '0;
	logic                        pop         = 1'b0;
	logic                        full;
	logic                        empty;
	logic [bst_pkg::ID_W-1:0]    token_id;
	logic                        token_present;
	logic                        text_done;
	logic [bst_pkg::CNT_W-1:0]   total_tokens;
	logic                        last_of_run;

	// tokenizer state as the predictor sees it, starting from reset values
	logic                        in_text   = 1'b0;
	logic                        capped    = 1'b0;
	logic [bst_pkg::WL_W-1:0]    word_len  = '0;
	logic [7:0]                  word_lead = '0;
	logic [1:0]                  utf_left  = '0;
	logic [bst_pkg::CP_W-1:0]    cp_acc    = '0;
	logic [bst_pkg::CNT_W-1:0]   tok_count = '0;
	logic [bst_pkg::CNT_W-1:0]   tok_limit = 16'hFFFF;

	token_result_t results_due [$];
	token_result_t step_out [MAX_PER_BYTE];
	int            step_n;

	// sender side
	cmd_t pending [$];
	logic open_text    = 1'b0;
	int   bytes_queued = 0;
	logic have_byte    = 1'b0;
	logic byte_taken   = 1'b0;
	int   burst_left   = 8;
	int   gap_left     = 0;
	int   quiet        = 0;

	// receiver side
	int          hold_asked   = 0;
	int          hold_served  = 0;
	int          hold_left    = 0;
	int          stretch_left = 0;
	logic [15:0] pop_pattern  = 16'hFFFF;

	// bookkeeping
	int cycles          = 0;
	int mismatches      = 0;
	int bytes_taken     = 0;
	int texts_ended     = 0;
	int results_checked = 0;
	int full_seen       = 0;

	byte_stream_tokenizer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.text_byte     (text_byte),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.empty         (empty),
		.pop           (pop),
		.token_id      (token_id),
		.token_present (token_present),
		.text_done     (text_done),
		.total_tokens  (total_tokens),
		.last_of_run   (last_of_run)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// one reset at the start, released on a falling edge
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------------
	// byte classes and token lookup
	// ---------------------------------------------------------------------

	function automatic logic space_byte(input logic [7:0] b);
		return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic punct_byte(input logic [7:0] b);
		return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
			(b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
	endfunction

	function automatic logic arabic_cp(input logic [bst_pkg::CP_W-1:0] c);
		return (c >= 21'h0600 && c <= 21'h06FF) || (c >= 21'h0750 && c <= 21'h077F) ||
			(c >= 21'h08A0 && c <= 21'h08FF) || (c >= 21'hFB50 && c <= 21'hFDFF) ||
			(c >= 21'hFE70 && c <= 21'hFEFF);
	endfunction

	function automatic logic [bst_pkg::ID_W-1:0] punct_token(input logic [7:0] b);
		logic [bst_pkg::ID_W-1:0] id;
		id = bst_pkg::TOK_UNK;
		for (int i = 0; i < 12; i++) begin
			if (VOCAB_PUNCT[i] == b && id == bst_pkg::TOK_UNK) begin
				id = bst_pkg::TOK_PUNCT_BASE + 14'(i);
			end
		end
		return id;
	endfunction

	// a limit of zero behaves as one
	function automatic int eff_limit();
		return (tok_limit == 0) ? 1 : int'(tok_limit);
	endfunction

	// ---------------------------------------------------------------------
	// token predictor
	// ---------------------------------------------------------------------

	task emit_token(input logic [bst_pkg::ID_W-1:0] id);
		step_out[step_n] = '{id: id, present: 1'b1, done: 1'b0, total: '0, last: 1'b0};
		step_n++;
		tok_count++;
	endtask

	// a lone digit is its own token, any other word is unknown
	task flush_word();
		logic [bst_pkg::ID_W-1:0] id;
		id = bst_pkg::TOK_UNK;
		if (word_len == 1 && word_lead >= CH_ZERO && word_lead <= CH_NINE) begin
			id = bst_pkg::TOK_DIGIT_BASE + 14'(word_lead - CH_ZERO);
		end
		emit_token(id);
		word_len  = '0;
		word_lead = '0;
	endtask

	// once the token count is one short of the limit, the rest of the text is dropped
	task room_check(output logic room);
		room = 1'b0;
		if (!capped) begin
			if (int'(tok_count) + 1 >= eff_limit()) begin
				capped = 1'b1;
			end else begin
				room = 1'b1;
			end
		end
	endtask

	task open_item(input logic [7:0] b);
		logic room;
		if (space_byte(b)) begin
			return;
		end
		room_check(room);
		if (!room) begin
			return;
		end
		if (b >= bst_pkg::LEAD2_MIN) begin
			if (b < bst_pkg::LEAD3_MIN) begin
				utf_left = 2'd1;
				cp_acc   = 21'(b & 8'h1F);
			end else if (b < bst_pkg::LEAD4_MIN) begin
				utf_left = 2'd2;
				cp_acc   = 21'(b & 8'h0F);
			end else begin
				utf_left = 2'd3;
				cp_acc   = 21'(b & 8'h07);
			end
		end else if (punct_byte(b)) begin
			emit_token(punct_token(b));
		end else begin
			word_len  = bst_pkg::WL_W'(1);
			word_lead = b;
			if (word_len >= bst_pkg::WORD_LIMIT) begin
				flush_word();
			end
		end
	endtask

	task predict_byte(input logic [7:0] b);
		step_n = 0;
		if (!in_text) begin
			in_text = 1'b1;
			emit_token(bst_pkg::TOK_BOS);
		end
		if (b == bst_pkg::TEXT_END) begin
			// pending word goes out before the end token; a cut sequence just vanishes
			if (word_len != 0) begin
				flush_word();
			end
			if (int'(tok_count) < eff_limit()) begin
				emit_token(bst_pkg::TOK_EOS);
			end
			if (step_n == 0) begin
				step_out[0] = '0;
				step_n = 1;
			end
			step_out[step_n-1].done  = 1'b1;
			step_out[step_n-1].total = tok_count;
			in_text     = 1'b0;
			capped      = 1'b0;
			word_len    = '0;
			word_lead   = '0;
			utf_left    = '0;
			cp_acc      = '0;
			tok_count   = '0;
			texts_ended++;
		end else if (capped) begin
			// dropped up to the end of the text
		end else if (utf_left != 0) begin
			cp_acc = {cp_acc[14:0], b[5:0]};
			utf_left--;
			if (utf_left == 0) begin
				if (arabic_cp(cp_acc)) begin
					emit_token(bst_pkg::ARABIC_BASE + 14'(int'(cp_acc) % ARABIC_MOD));
				end else begin
					emit_token(bst_pkg::OTHER_BASE + 14'(int'(cp_acc) % OTHER_MOD));
				end
				cp_acc = '0;
			end
		end else if (word_len != 0) begin
			// inside a word a high byte is just another word byte
			if (space_byte(b)) begin
				flush_word();
			end else if (punct_byte(b)) begin
				flush_word();
				open_item(b);
			end else begin
				word_len++;
				if (word_len >= bst_pkg::WORD_LIMIT) begin
					flush_word();
				end
			end
		end else begin
			open_item(b);
		end
		if (step_n > 0) begin
			step_out[step_n-1].last = 1'b1;
		end
		for (int i = 0; i < step_n; i++) begin
			results_due.push_back(step_out[i]);
		end
	endtask

	// ---------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------

	task add_cmd(input cmd_kind_t kind, input logic [15:0] value);
		pending.push_back('{kind: kind, value: value});
	endtask

	task add_byte(input logic [7:0] b);
		add_cmd(CMD_BYTE, {8'h00, b});
		bytes_queued++;
		open_text = (b != bst_pkg::TEXT_END);
	endtask

	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : 8'(8'h09 + r);
	endfunction

	function automatic logic [7:0] pick_punct();
		logic [7:0] b;
		if ($urandom_range(0, 3) != 0) begin
			return VOCAB_PUNCT[$urandom_range(0, 11)];
		end
		do begin
			b = 8'($urandom_range(8'h21, 8'h7E));
		end while (!punct_byte(b));
		return b;
	endfunction

	// bytes that can open a word: not blank, not punctuation, not a sequence lead
	function automatic logic [7:0] pick_word_start();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(1, 8'hBF));
		end while (space_byte(b) || punct_byte(b));
		return b;
	endfunction

	function automatic logic [7:0] pick_word_more();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(1, 255));
		end while (space_byte(b) || punct_byte(b));
		return b;
	endfunction

	function automatic logic [7:0] pick_follow();
		if ($urandom_range(0, 7) == 0) begin
			return 8'($urandom_range(1, 255));
		end
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	task add_word(input int len);
		add_byte(pick_word_start());
		for (int i = 1; i < len; i++) begin
			add_byte(pick_word_more());
		end
	endtask

	// either a well-formed arabic letter or a random lead with unchecked followers
	task add_utf();
		logic [bst_pkg::CP_W-1:0] c;
		int n;
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 4))
				0: c = 21'($urandom_range(21'h0600, 21'h06FF));
				1: c = 21'($urandom_range(21'h0750, 21'h077F));
				2: c = 21'($urandom_range(21'h08A0, 21'h08FF));
				3: c = 21'($urandom_range(21'hFB50, 21'hFDFF));
				default: c = 21'($urandom_range(21'hFE70, 21'hFEFF));
			endcase
			if (c < 21'h0800) begin
				add_byte({3'b110, c[10:6]});
			end else begin
				add_byte({4'b1110, c[15:12]});
				add_byte({2'b10, c[11:6]});
			end
			add_byte({2'b10, c[5:0]});
		end else begin
			n = $urandom_range(1, 3);
			case (n)
				1: add_byte(8'($urandom_range(8'hC0, 8'hDF)));
				2: add_byte(8'($urandom_range(8'hE0, 8'hEF)));
				default: add_byte(8'($urandom_range(8'hF0, 8'hFF)));
			endcase
			for (int i = 0; i < n; i++) begin
				add_byte(pick_follow());
			end
		end
	endtask

	task add_piece();
		case ($urandom_range(0, 9))
			0, 1: add_byte(pick_space());
			2, 3: add_byte(pick_punct());
			4: add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
			5, 6: begin
				// now and then a word long enough to be split
				if ($urandom_range(0, 9) == 0) begin
					add_word($urandom_range(55, 140));
				end else begin
					add_word($urandom_range(1, 8));
				end
				if ($urandom_range(0, 3) != 0) begin
					add_byte(($urandom_range(0, 1) == 0) ? pick_space() : pick_punct());
				end
			end
			7, 8: add_utf();
			default: add_byte(8'($urandom_range(1, 255)));
		endcase
	endtask

	task end_text();
		// sometimes the end cuts a sequence short
		if ($urandom_range(0, 4) == 0) begin
			add_byte(8'($urandom_range(8'hC0, 8'hFF)));
		end
		add_byte(bst_pkg::TEXT_END);
	endtask

	// texts are allowed to run across a limit change
	task add_run(input int budget);
		int start;
		start = bytes_queued;
		while (bytes_queued - start < budget) begin
			if (open_text && $urandom_range(0, 9) == 0) begin
				end_text();
			end else begin
				add_piece();
			end
		end
	endtask

	task build_stimulus();
		// directed, at the reset limit: empty text, then digits, punctuation,
		// a high byte inside a word, utf-8 of two and four bytes and a word left open
		add_byte(bst_pkg::TEXT_END);
		add_byte(CH_ZERO);
		add_byte(CH_SPACE);
		add_byte(CH_NINE);
		add_byte(8'h28);
		add_byte(8'h61);
		add_byte(8'hFF);
		add_byte(8'h21);
		add_byte(8'hC3);
		add_byte(8'hA9);
		add_byte(8'hD8);
		add_byte(8'hA7);
		add_byte(8'hF4);
		add_byte(8'h8F);
		add_byte(8'hBF);
		add_byte(8'hBF);
		add_byte(8'h35);
		add_byte(bst_pkg::TEXT_END);
		// sequence cut by the end of text
		add_byte(8'hE0);
		add_byte(8'h80);
		add_byte(bst_pkg::TEXT_END);
		// limit one: no room for the end token, bare end report
		add_cmd(CMD_CFG, 16'd1);
		add_byte(8'h61);
		add_byte(bst_pkg::TEXT_END);
		// limit zero behaves as one
		add_cmd(CMD_CFG, 16'd0);
		add_byte(bst_pkg::TEXT_END);
		// limit lowered in the middle of a text
		add_cmd(CMD_CFG, 16'hFFFF);
		add_byte(8'h28);
		add_byte(8'h28);
		add_cmd(CMD_CFG, 16'd3);
		add_byte(8'h28);
		add_byte(bst_pkg::TEXT_END);

		// random texts under a series of limits
		add_cmd(CMD_CFG, 16'hFFFF);
		add_cmd(CMD_HOLD, 16'd0);
		add_run(130);
		add_cmd(CMD_CFG, 16'd1);
		add_run(30);
		add_cmd(CMD_CFG, 16'($urandom_range(41, 65534)));
		add_run(110);
		add_cmd(CMD_CFG, 16'd0);
		add_run(25);
		add_cmd(CMD_CFG, 16'($urandom_range(3, 8)));
		add_run(40);
		add_cmd(CMD_CFG, 16'd2);
		add_run(30);
		add_cmd(CMD_CFG, 16'($urandom_range(9, 40)));
		add_run(90);
		add_cmd(CMD_CFG, 16'hFFFF);
		add_run(50);
		add_cmd(CMD_DRAIN, 16'd0);
		add_run(50);
		end_text();
	endtask

	// ---------------------------------------------------------------------
	// sender: item taken on a rising edge, next one set up on the falling edge
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_byte(text_byte);
				bytes_taken++;
				byte_taken = 1'b1;
			end
			if (push && full) begin
				full_seen++;
			end
			if (cfg_wr_en) begin
				tok_limit = cfg_wr_data;
			end
		end
	end

	always @(negedge clk) begin
		cmd_t cmd;
		logic next_push;
		logic next_cfg;
		next_push = 1'b0;
		next_cfg  = 1'b0;
		if (arst_n) begin
			if (byte_taken) begin
				byte_taken = 1'b0;
				have_byte  = 1'b0;
			end
			// idle time since the last expected result came back
			if (have_byte || results_due.size() != 0) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (have_byte) begin
				next_push = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending.size() != 0) begin
				cmd = pending[0];
				case (cmd.kind)
					CMD_BYTE: begin
						pending.pop_front();
						text_byte <= cmd.value[7:0];
						next_push = 1'b1;
						have_byte = 1'b1;
						if (burst_left > 1) begin
							burst_left--;
						end else begin
							// some bursts are long and gapless, some gaps are zero
							burst_left = ($urandom_range(0, 5) == 0) ?
								$urandom_range(40, 120) : $urandom_range(1, 20);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
						end
					end
					CMD_CFG: begin
						// register writes only once the block has gone quiet
						if (quiet >= SETTLE_CYCLES) begin
							pending.pop_front();
							cfg_wr_data <= cmd.value;
							next_cfg = 1'b1;
							quiet    = 0;
						end
					end
					CMD_DRAIN: begin
						if (quiet >= SETTLE_CYCLES) begin
							pending.pop_front();
						end
					end
					CMD_HOLD: begin
						pending.pop_front();
						hold_asked++;
					end
					default: begin
						pending.pop_front();
					end
				endcase
			end
		end
		push      <= next_push;
		cfg_wr_en <= next_cfg;
	end

	// ---------------------------------------------------------------------
	// receiver: pop follows a rotating pattern that changes per stretch,
	// with one long hold-off on request
	// ---------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
			end else if (hold_served != hold_asked) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(20, 120);
					case ($urandom_range(0, 3))
						0: pop_pattern = 16'hFFFF;
						1: pop_pattern = 16'($urandom) | 16'h0001;
						2: pop_pattern = 16'h0101 | (16'($urandom) & 16'h1010);
						default: pop_pattern = ~(16'h0001 << $urandom_range(0, 15));
					endcase
				end
				stretch_left--;
				pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
			end
			pop <= (hold_left == 0) && pop_pattern[0];
		end
	end

	task report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_checked, what, got, want);
		end
	endtask

	// each accepted result against the oldest expectation, field by field
	always @(posedge clk) begin
		token_result_t want;
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with none expected, token_id", token_id, 0);
			end else begin
				want = results_due.pop_front();
				if (token_id !== want.id) begin
					report_mismatch("token_id", token_id, want.id);
				end
				if (token_present !== want.present) begin
					report_mismatch("token_present", token_present, want.present);
				end
				if (text_done !== want.done) begin
					report_mismatch("text_done", text_done, want.done);
				end
				if (total_tokens !== want.total) begin
					report_mismatch("total_tokens", total_tokens, want.total);
				end
				if (last_of_run !== want.last) begin
					report_mismatch("last_of_run", last_of_run, want.last);
				end
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", results_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		wait (arst_n);
		while (pending.size() != 0 || have_byte || results_due.size() != 0) begin
			@(posedge clk);
		end
		// anything that shows up now was never predicted
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (results_due.size() != 0) begin
			report_mismatch("results left undelivered", results_due.size(), 0);
		end
		$display("ran %0d bytes in %0d texts, %0d results checked, input stalled %0d cycles",
			bytes_taken, texts_ended, results_checked, full_seen);
		$display("limits 0, 1, 2, small, mid and 65535 incl. changes inside a text; %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
